/* hw/rtl/i2d_pkg.sv */
// Shared types and constants for the integer to double converter.
// No dependencies; imported by every module of the block.
package i2d_pkg;

    localparam logic [10:0] EXP_BASE = 11'd1086;

    // Sign and magnitude after extension and negation.
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_mag;

    // Partly or fully normalized magnitude with the shift taken so far.
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [5:0]  lz;
        logic [63:0] val;
    } t_nrm;

endpackage

/* hw/rtl/i2d_mag.sv */
// First stage: word extension, sign detection and two's complement magnitude.
// Depends on i2d_pkg.
module i2d_mag (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [63:0]    i_operand,
    input  logic           i_is_signed,
    input  logic           i_is_word32,
    output logic           o_valid,
    input  logic           i_stall,
    output i2d_pkg::t_mag  o_data
);
    import i2d_pkg::*;

    logic        r_v;
    t_mag        r_d;
    t_mag        n_d;
    logic        ready;
    logic [63:0] ext;

    always_comb begin
        if (!i_is_word32) begin
            ext      = i_operand;
            n_d.neg  = i_is_signed & i_operand[63];
        end else if (i_is_signed && i_operand[31]) begin
            ext      = {32'hffff_ffff, i_operand[31:0]};
            n_d.neg  = 1'b1;
        end else begin
            ext      = {32'h0, i_operand[31:0]};
            n_d.neg  = 1'b0;
        end
        n_d.mag = n_d.neg ? (~ext + 64'd1) : ext;
    end

    assign ready   = !r_v || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_d <= n_d;
        end
    end

endmodule

/* hw/rtl/i2d_norm.sv */
// Two-stage normalizer: leading zeros shifted out by 32/16/8, then by 4/2/1.
// Depends on i2d_pkg.
module i2d_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  i2d_pkg::t_mag  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output i2d_pkg::t_nrm  o_data
);
    import i2d_pkg::*;

    logic r_v1;
    logic r_v2;
    t_nrm r_d1;
    t_nrm r_d2;
    t_nrm n_d1;
    t_nrm n_d2;
    logic ready1;
    logic ready2;

    // coarse steps
    always_comb begin
        n_d1.neg  = i_data.neg;
        n_d1.zero = (i_data.mag == 64'd0);
        n_d1.lz   = 6'd0;
        n_d1.val  = i_data.mag;
        if (n_d1.val[63:32] == 32'd0) begin
            n_d1.val   = n_d1.val << 32;
            n_d1.lz[5] = 1'b1;
        end
        if (n_d1.val[63:48] == 16'd0) begin
            n_d1.val   = n_d1.val << 16;
            n_d1.lz[4] = 1'b1;
        end
        if (n_d1.val[63:56] == 8'd0) begin
            n_d1.val   = n_d1.val << 8;
            n_d1.lz[3] = 1'b1;
        end
    end

    // fine steps
    always_comb begin
        n_d2 = r_d1;
        if (n_d2.val[63:60] == 4'd0) begin
            n_d2.val   = n_d2.val << 4;
            n_d2.lz[2] = 1'b1;
        end
        if (n_d2.val[63:62] == 2'd0) begin
            n_d2.val   = n_d2.val << 2;
            n_d2.lz[1] = 1'b1;
        end
        if (!n_d2.val[63]) begin
            n_d2.val   = n_d2.val << 1;
            n_d2.lz[0] = 1'b1;
        end
    end

    assign ready2  = !r_v2 || !i_stall;
    assign ready1  = !r_v1 || ready2;
    assign o_stall = !ready1;
    assign o_valid = r_v2;
    assign o_data  = r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r_d1 <= n_d1;
        end
        if (ready2 && r_v1) begin
            r_d2 <= n_d2;
        end
    end

endmodule

/* hw/rtl/i2d_round.sv */
// Last stage: exponent, round to nearest even, sign; holds the output register.
// Depends on i2d_pkg.
module i2d_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  i2d_pkg::t_nrm  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [63:0]    o_double_bits
);
    import i2d_pkg::*;

    logic        r_v;
    logic [63:0] r_bits;
    logic [63:0] n_bits;
    logic        ready;
    logic [10:0] exp;
    logic        guard;
    logic        sticky;
    logic        up;
    logic [62:0] mag_bits;

    always_comb begin
        exp      = EXP_BASE - {5'd0, i_data.lz};
        guard    = i_data.val[10];
        sticky   = |i_data.val[9:0];
        up       = guard & (sticky | i_data.val[11]);
        // a carry out of the fraction lands in the exponent
        mag_bits = {exp, i_data.val[62:11]} + {62'd0, up};
        n_bits   = i_data.zero ? 64'd0 : {i_data.neg, mag_bits};
    end

    assign ready         = !r_v || !i_stall;
    assign o_stall       = !ready;
    assign o_valid       = r_v;
    assign o_double_bits = r_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_bits <= n_bits;
        end
    end

endmodule

/* hw/rtl/int_to_double_convert.sv */
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_operand[63:0], i_is_signed, i_is_word32
// result    out        o_valid / i_stall  o_double_bits[63:0]
//
// Four register stages: magnitude, coarse normalize, fine normalize, round.
// One item per cycle is accepted when the output is not stalled.
// Each stage holds its item while the next is full and stalled; empty stages fill.
// Synchronous active-low reset clears the valid bits only.
// Depends on i2d_pkg, i2d_mag, i2d_norm, i2d_round.
module int_to_double_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_operand,
    input  logic        i_is_signed,
    input  logic        i_is_word32,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_double_bits
);
    import i2d_pkg::*;

    logic mag_valid;
    logic mag_stall;
    t_mag mag_data;
    logic nrm_valid;
    logic nrm_stall;
    t_nrm nrm_data;

    i2d_mag u_mag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operand   (i_operand),
        .i_is_signed (i_is_signed),
        .i_is_word32 (i_is_word32),
        .o_valid     (mag_valid),
        .i_stall     (mag_stall),
        .o_data      (mag_data)
    );

    i2d_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mag_valid),
        .o_stall (mag_stall),
        .i_data  (mag_data),
        .o_valid (nrm_valid),
        .i_stall (nrm_stall),
        .o_data  (nrm_data)
    );

    i2d_round u_round (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (nrm_valid),
        .o_stall       (nrm_stall),
        .i_data        (nrm_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_double_bits (o_double_bits)
    );

endmodule

/* tb/sv/int_to_double_convert_tb.sv */
// Self-checking bench for int_to_double_convert: directed corner operands, then random
// operands with gaps on both sides, results checked in order against a local converter.
// Depends on i2d_pkg and the int_to_double_convert RTL.

// One converted operand waiting for its result.
typedef struct {
    logic [63:0] operand;
    logic        is_signed;
    logic        is_word32;
    logic [63:0] double_bits;
} t_conv_entry;

class conversion_scoreboard;
    t_conv_entry pending_q[$];
    int          mismatches;

    // Integer to binary64, round to nearest even.
    static function automatic logic [63:0] int_to_double(logic [63:0] op, logic sgn,
                                                         logic w32);
        logic [63:0] ext;
        logic [63:0] mag;
        logic [63:0] norm;
        logic        neg;
        int          lz;
        logic [10:0] expo;
        logic        round_up;
        logic [63:0] bits;
        if (!w32) begin
            ext = op;
            neg = sgn & op[63];
        end else if (sgn && op[31]) begin
            ext = {32'hffff_ffff, op[31:0]};
            neg = 1'b1;
        end else begin
            ext = {32'h0, op[31:0]};
            neg = 1'b0;
        end
        mag = neg ? -ext : ext;
        if (mag == 64'd0)
            return 64'd0;
        lz = 0;
        while (!mag[63 - lz])
            lz++;
        norm = mag << lz;
        expo = i2d_pkg::EXP_BASE - 11'(lz);
        // guard set and (sticky or odd lsb)
        round_up = norm[10] & ((|norm[9:0]) | norm[11]);
        bits = {1'b0, expo, norm[62:11]} + 64'(round_up);
        bits[63] = neg;
        return bits;
    endfunction

    function void note_operand(logic [63:0] op, logic sgn, logic w32);
        t_conv_entry e;
        e.operand = op;
        e.is_signed = sgn;
        e.is_word32 = w32;
        e.double_bits = int_to_double(op, sgn, w32);
        pending_q.push_back(e);
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [63:0] got);
        t_conv_entry e;
        if (pending_q.size() == 0) begin
            report($sformatf("result %h with no item outstanding", got));
            return;
        end
        e = pending_q.pop_front();
        if (got !== e.double_bits)
            report($sformatf("op=%h signed=%0b word=%0b expected %h got %h",
                             e.operand, e.is_signed, e.is_word32, e.double_bits, got));
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction

    function void flag_leftovers();
        t_conv_entry e;
        while (pending_q.size() != 0) begin
            e = pending_q.pop_front();
            report($sformatf("no result for op=%h", e.operand));
        end
    endfunction
endclass

module int_to_double_convert_tb;
    localparam int RANDOM_ITEMS = 1530;
    localparam int HOLD_CYCLES  = 80;
    localparam int BURST_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_operand = '0;
    logic        i_is_signed = 1'b0;
    logic        i_is_word32 = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_double_bits;

    conversion_scoreboard sb = new();
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    int_to_double_convert DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operand     (i_operand),
        .i_is_signed   (i_is_signed),
        .i_is_word32   (i_is_word32),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_double_bits (o_double_bits)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short idle runs, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Starts at a clock edge and returns at the edge where the item is taken.
    task automatic offer_operand(logic [63:0] op, logic sgn, logic w32);
        i_valid <= 1'b1;
        i_operand <= op;
        i_is_signed <= sgn;
        i_is_word32 <= w32;
        do @(posedge i_clk); while (o_stall);
        sb.note_operand(op, sgn, w32);
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Biased toward shift counts, ties, near-ties and rounding carries.
    function automatic void pick_operand(output logic [63:0] op, output logic sgn,
                                         output logic w32);
        logic [63:0] rnd;
        logic [52:0] body;
        logic [63:0] half;
        logic [63:0] low;
        int          d;
        rnd = {$urandom(), $urandom()};
        sgn = 1'($urandom_range(0, 1));
        w32 = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0: op = rnd;
            1: op = rnd >> $urandom_range(0, 63);
            2, 3: begin
                d = $urandom_range(1, 11);
                body = ($urandom_range(0, 3) == 0) ? '1 : {1'b1, rnd[51:0]};
                half = 64'd1 << (d - 1);
                case ($urandom_range(0, 3))
                    0: low = half;
                    1: low = (d > 1) ? half + 64'd1 : half;
                    2: low = (d > 1) ? half - 64'd1 : 64'd0;
                    default: low = {$urandom(), $urandom()} & ((64'd1 << d) - 64'd1);
                endcase
                op = ({11'd0, body} << d) | low;
                w32 = 1'b0;
                if (sgn && $urandom_range(0, 1))
                    op = -op;
            end
            4: op = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            default: begin
                op = rnd;
                w32 = 1'b1;
            end
        endcase
    endfunction

    // Result side: random stall runs, smooth stretches, and one long hold when asked.
    initial begin
        int r;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    i_stall <= 1'b0;
                    repeat (50) @(posedge i_clk);
                end else if (r < 4) begin
                    i_stall <= 1'b1;
                    repeat (idle_len() + 1) @(posedge i_clk);
                end else begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_result(o_double_bits);
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [63:0] op;
        logic        sgn;
        logic        w32;
        int          gap;
        int          burst_left;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zeros, extremes, most negative, word extension
        offer_operand(64'd0, 1'b0, 1'b0);
        offer_operand(64'd0, 1'b1, 1'b0);
        offer_operand(64'hdead_beef_0000_0000, 1'b1, 1'b1);
        offer_operand(64'd1, 1'b0, 1'b0);
        offer_operand(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
        offer_operand(64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
        offer_operand(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        offer_operand(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        offer_operand(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0);
        offer_operand(64'h1234_5678_8000_0000, 1'b1, 1'b1);
        offer_operand(64'h1234_5678_8000_0000, 1'b0, 1'b1);
        offer_operand(64'hffff_ffff_ffff_ffff, 1'b1, 1'b1);
        offer_operand(64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
        offer_operand(64'h0000_0000_7fff_ffff, 1'b1, 1'b1);
        // tie with even lsb, tie with odd lsb, just above half, just below half
        offer_operand(64'h8000_0000_0000_0400, 1'b0, 1'b0);
        offer_operand(64'h8000_0000_0000_0c00, 1'b0, 1'b0);
        offer_operand(64'h8000_0000_0000_0401, 1'b0, 1'b0);
        offer_operand(64'h8000_0000_0000_03ff, 1'b0, 1'b0);
        // rounding carry into the exponent, then a tie that rounds down to even
        offer_operand(64'hffff_ffff_ffff_fc00, 1'b0, 1'b0);
        offer_operand(64'h003f_ffff_ffff_ffff, 1'b0, 1'b0);
        offer_operand(64'h0020_0000_0000_0001, 1'b1, 1'b0);
        i_valid <= 1'b0;
        wait_drained();

        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 500) begin
                hold_req = 1'b1;
                burst_left = BURST_ITEMS;
            end
            if (i == 1000) begin
                i_valid <= 1'b0;
                wait_drained();
            end
            pick_operand(op, sgn, w32);
            offer_operand(op, sgn, w32);
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else if ((i % 300) < 50) begin
                gap = 0;
            end else begin
                gap = idle_len();
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
